### hdl/lrup_pkg.sv
`timescale 1ns / 1ps
// shared field widths, stream layouts and lookup flag type for the lru page replacement block
package lrup_pkg;

    localparam int unsigned PAGE_W      = 8;
    localparam int unsigned SLOT_W      = 2;
    localparam int unsigned FCOUNT_W    = 16;

    localparam int unsigned S_TDATA_W   = 8;

    // result beat layout, lowest bit first
    localparam int unsigned HIT_LSB     = 0;
    localparam int unsigned SLOT_LSB    = HIT_LSB + 1;
    localparam int unsigned EVV_LSB     = SLOT_LSB + SLOT_W;
    localparam int unsigned EVP_LSB     = EVV_LSB + 1;
    localparam int unsigned FCOUNT_LSB  = EVP_LSB + PAGE_W;
    localparam int unsigned M_USED_W    = FCOUNT_LSB + FCOUNT_W;
    localparam int unsigned M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    localparam logic [FCOUNT_W-1:0] FCOUNT_MAX = '1;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_lkp_flags;

endpackage

### hdl/lrup_lookup.sv
`timescale 1ns / 1ps
// frame lookup: parallel compare, empty frame search and victim choice
module lrup_lookup #(
    parameter int unsigned FRAMES    = 4,
    parameter int unsigned PAGE_BITS = 8,
    parameter int unsigned IDX_W     = 2
) (
    input  logic [PAGE_BITS-1:0]             i_page,
    input  logic [FRAMES-1:0][PAGE_BITS-1:0] i_frame_page,
    input  logic [FRAMES-1:0]                i_frame_valid,
    input  logic [FRAMES-1:0][IDX_W-1:0]     i_rank,
    output lrup_pkg::t_lkp_flags             o_flags,
    output logic [IDX_W-1:0]                 o_slot
);
    import lrup_pkg::*;

    logic             hit_any;
    logic             empty_any;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] empty_idx;
    logic [IDX_W-1:0] lru_idx;

    always_comb begin
        hit_any   = 1'b0;
        empty_any = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        lru_idx   = '0;
        // scan downward so the lowest index wins
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (i_frame_valid[i] && (i_frame_page[i] == i_page)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!i_frame_valid[i]) begin
                empty_any = 1'b1;
                empty_idx = IDX_W'(i);
            end
            if (i_rank[i] == '0) begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_flags.hit   = hit_any;
        o_flags.evict = !hit_any && !empty_any;
        priority if (hit_any) begin
            o_slot = hit_idx;
        end else if (empty_any) begin
            o_slot = empty_idx;
        end else begin
            o_slot = lru_idx;
        end
    end

endmodule

### hdl/lrup_rank.sv
`timescale 1ns / 1ps
// recency rank update: touched frame becomes newest, newer frames shift down
module lrup_rank #(
    parameter int unsigned FRAMES = 4,
    parameter int unsigned IDX_W  = 2
) (
    input  logic [FRAMES-1:0][IDX_W-1:0] i_rank,
    input  logic [IDX_W-1:0]             i_slot,
    output logic [FRAMES-1:0][IDX_W-1:0] o_rank
);
    import lrup_pkg::*;

    logic [IDX_W-1:0] old_rank;

    always_comb begin
        old_rank = i_rank[i_slot];
        for (int i = 0; i < FRAMES; i++) begin
            if (IDX_W'(i) == i_slot) begin
                o_rank[i] = IDX_W'(FRAMES - 1);
            end else if (i_rank[i] > old_rank) begin
                o_rank[i] = i_rank[i] - IDX_W'(1);
            end else begin
                o_rank[i] = i_rank[i];
            end
        end
    end

endmodule

### hdl/lru_page_replacement.sv
`timescale 1ns / 1ps
// top level of the lru page replacement block
// Takes one page reference per beat and answers with one result beat: hit,
// frame slot, evicted page and the saturating fault count. Ranks give true
// LRU over FRAMES frames; empty frames fill lowest first. A beat with tlast
// gets a normal answer, then the frames, ranks and fault count return to
// their reset state. One beat per clock is sustained unless m_axis_tready
// stalls the result register: a reference sits in an input register and is
// resolved against the frame table in the cycle that moves it into the
// result register, so the next reference already sees the updated table.
module lru_page_replacement #(
    parameter int unsigned FRAMES    = 4,
    parameter int unsigned PAGE_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // page[7:0]
    input  logic [lrup_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // hit[0], slot[2:1], evicted_valid[3], evicted_page[11:4],
    // fault_count[27:12], zero fill above
    output logic [lrup_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import lrup_pkg::*;

    localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // input register
    logic                 r_in_valid;
    logic [PAGE_W-1:0]    r_in_page;
    logic                 r_in_last;

    // frame table
    logic [FRAMES-1:0][PAGE_BITS-1:0] r_frame_page;
    logic [FRAMES-1:0]                r_frame_valid;
    logic [FRAMES-1:0][IDX_W-1:0]     r_rank;
    logic [FCOUNT_W-1:0]              r_faults;

    // result register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_evv;
    logic [PAGE_W-1:0]    r_out_evp;
    logic [FCOUNT_W-1:0]  r_out_fcount;

    logic                             advance;
    logic [PAGE_BITS+PAGE_W-1:0]      page_ext;
    logic [PAGE_BITS-1:0]             page_m;
    t_lkp_flags                       flags;
    logic [IDX_W-1:0]                 slot;
    logic [FRAMES-1:0][IDX_W-1:0]     n_rank;
    logic [FCOUNT_W-1:0]              n_faults;
    logic [IDX_W+SLOT_W-1:0]          slot_ext;
    logic [PAGE_BITS+PAGE_W-1:0]      evp_ext;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign page_ext = {{PAGE_BITS{1'b0}}, r_in_page};
    assign page_m   = page_ext[PAGE_BITS-1:0];

    lrup_lookup #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_lookup (
        .i_page        (page_m),
        .i_frame_page  (r_frame_page),
        .i_frame_valid (r_frame_valid),
        .i_rank        (r_rank),
        .o_flags       (flags),
        .o_slot        (slot)
    );

    lrup_rank #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_rank (
        .i_rank (r_rank),
        .i_slot (slot),
        .o_rank (n_rank)
    );

    always_comb begin
        if (!flags.hit && (r_faults != FCOUNT_MAX)) begin
            n_faults = r_faults + FCOUNT_W'(1);
        end else begin
            n_faults = r_faults;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, slot};
    assign evp_ext  = {{PAGE_W{1'b0}}, r_frame_page[slot]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_page <= s_axis_tdata[PAGE_W-1:0];
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= '0;
            r_faults      <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= IDX_W'(i);
            end
        end else if (advance) begin
            if (r_in_last) begin
                r_frame_valid <= '0;
                r_faults      <= '0;
                for (int i = 0; i < FRAMES; i++) begin
                    r_rank[i] <= IDX_W'(i);
                end
            end else begin
                if (!flags.hit) begin
                    r_frame_valid[slot] <= 1'b1;
                end
                r_faults <= n_faults;
                r_rank   <= n_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !flags.hit) begin
            r_frame_page[slot] <= page_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_hit    <= flags.hit;
            r_out_slot   <= slot_ext[SLOT_W-1:0];
            r_out_evv    <= flags.evict;
            r_out_evp    <= flags.evict ? evp_ext[PAGE_W-1:0] : '0;
            r_out_fcount <= n_faults;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_fcount, r_out_evp, r_out_evv,
                                       r_out_slot, r_out_hit});

endmodule

### tb/sv/lru_page_replacement_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for lru_page_replacement: directed, fault thrash and random reference runs
module lru_page_replacement_tb;
    import lrup_pkg::*;

    localparam int unsigned FRAMES      = 4;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_WAIT  = 8;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                evicted_valid;
        logic [PAGE_W-1:0]   evicted_page;
        logic [FCOUNT_W-1:0] fault_count;
    } t_lookup;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    logic                 src_idle_en = 1'b0;
    logic                 snk_idle_en = 1'b0;
    int unsigned          cycles = 0;
    int unsigned          errors = 0;

    // shadow frame table
    logic [PAGE_W-1:0]    frame_pg [FRAMES];
    logic                 frame_vld [FRAMES];
    int unsigned          frame_rank [FRAMES];
    logic [FCOUNT_W-1:0]  fault_total;

    t_lookup              pending_lookups [$];

    lru_page_replacement u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("lru_page_replacement_tb: FAIL");
            $finish;
        end
    end

    function automatic void clear_frames();
        for (int i = 0; i < FRAMES; i++) begin
            frame_pg[i]   = '0;
            frame_vld[i]  = 1'b0;
            frame_rank[i] = i;
        end
        fault_total = '0;
    endfunction

    function automatic t_lookup lookup_page(input logic [PAGE_W-1:0] pg, input logic lst);
        t_lookup     r;
        int          s;
        int unsigned old;
        r = '0;
        s = -1;
        for (int i = 0; i < FRAMES; i++)
            if (s < 0 && frame_vld[i] && frame_pg[i] == pg) s = i;
        if (s >= 0) begin
            r.hit = 1'b1;
        end else begin
            for (int i = 0; i < FRAMES; i++)
                if (s < 0 && !frame_vld[i]) s = i;
            if (s < 0) begin
                for (int i = 0; i < FRAMES; i++)
                    if (s < 0 && frame_rank[i] == 0) s = i;
                if (s < 0) s = 0;
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_pg[s];
            end
            frame_pg[s]  = pg;
            frame_vld[s] = 1'b1;
            if (fault_total != FCOUNT_MAX) fault_total = fault_total + 1'b1;
        end
        // move frame s to most recently used
        old = frame_rank[s];
        for (int i = 0; i < FRAMES; i++)
            if (frame_rank[i] > old) frame_rank[i] = frame_rank[i] - 1;
        frame_rank[s] = FRAMES - 1;
        r.slot        = s[SLOT_W-1:0];
        r.fault_count = fault_total;
        if (lst) clear_frames();
        return r;
    endfunction

    task automatic report_field(input string name, input logic [FCOUNT_W-1:0] e,
                                input logic [FCOUNT_W-1:0] a);
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, e, a);
        errors++;
    endtask

    task automatic check_lookup(input logic [M_TDATA_W-1:0] beat);
        t_lookup got;
        t_lookup exp;
        got.hit           = beat[HIT_LSB];
        got.slot          = beat[SLOT_LSB +: SLOT_W];
        got.evicted_valid = beat[EVV_LSB];
        got.evicted_page  = beat[EVP_LSB +: PAGE_W];
        got.fault_count   = beat[FCOUNT_LSB +: FCOUNT_W];
        if (pending_lookups.size() == 0) begin
            $display("%0t ns: result beat with none expected, expected none actual %0h",
                     $time, beat);
            errors++;
        end else begin
            exp = pending_lookups.pop_front();
            if (got.hit !== exp.hit)
                report_field("hit", FCOUNT_W'(exp.hit), FCOUNT_W'(got.hit));
            if (got.slot !== exp.slot)
                report_field("slot", FCOUNT_W'(exp.slot), FCOUNT_W'(got.slot));
            if (got.evicted_valid !== exp.evicted_valid)
                report_field("evicted_valid", FCOUNT_W'(exp.evicted_valid),
                             FCOUNT_W'(got.evicted_valid));
            if (got.evicted_page !== exp.evicted_page)
                report_field("evicted_page", FCOUNT_W'(exp.evicted_page),
                             FCOUNT_W'(got.evicted_page));
            if (got.fault_count !== exp.fault_count)
                report_field("fault_count", exp.fault_count, got.fault_count);
        end
    endtask

    // result side: sample before the edge, check after it, stall in bursts
    initial begin : result_sink
        int                   stall;
        logic                 fire;
        logic [M_TDATA_W-1:0] beat;
        stall = 0;
        forever begin
            @(negedge i_clk);
            fire = (m_axis_tvalid === 1'b1) && m_axis_tready;
            beat = m_axis_tdata;
            @(posedge i_clk);
            if (fire) check_lookup(beat);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic lst);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pg;
        s_axis_tlast  <= lst;
        forever begin
            @(negedge i_clk);
            if (s_axis_tready === 1'b1) break;
        end
        @(posedge i_clk);
        pending_lookups.push_back(lookup_page(pg, lst));
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_refs();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_ref(8'h00, 1'b0);
        send_ref(8'hFF, 1'b0);
        send_ref(8'h00, 1'b0);
        send_ref(8'h80, 1'b0);
        send_ref(8'h7F, 1'b0);
        send_ref(8'hFF, 1'b0);
        // table full: faults now replace the least recently used frame
        send_ref(8'h55, 1'b0);
        send_ref(8'hAA, 1'b0);
        send_ref(8'h7F, 1'b0);
        send_ref(8'h00, 1'b0);
        send_ref(8'hFF, 1'b0);
        send_ref(8'h55, 1'b1);
        // fresh table after last request
        send_ref(8'h55, 1'b0);
        send_ref(8'h01, 1'b1);
        send_ref(8'h02, 1'b0);
        send_ref(8'h02, 1'b1);
        send_ref(8'hAA, 1'b0);
        send_ref(8'h55, 1'b0);
        send_ref(8'hAA, 1'b1);
    endtask

    task automatic test_fault_thrash();
        wait_results();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        // five pages cycled over four frames fault on every reference
        for (int n = 0; n < 40; n++) send_ref(PAGE_W'(n % 5), 1'b0);
        send_ref(8'h03, 1'b0);
        send_ref(8'h09, 1'b1);
    endtask

    task automatic test_random_refs();
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] pg;
        base = PAGE_W'($urandom_range(0, 255));
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int n = 0; n < 640; n++) begin
            if (n == 320) wait_results();
            if (n == 480) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            if ($urandom_range(0, 49) == 0) base = PAGE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) pg = PAGE_W'($urandom_range(0, 255));
            else pg = PAGE_W'(base + $urandom_range(0, 5));
            send_ref(pg, $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        clear_frames();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_refs();
        test_fault_thrash();
        test_random_refs();
        wait_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_lookups.size() == 0) begin
            $display("lru_page_replacement_tb: PASS");
        end else begin
            $display("lru_page_replacement_tb: FAIL");
        end
        $finish;
    end

endmodule
